@@ rtl/core/rlm_pkg.sv @@
// Shared types and codes for the LED matrix scan controller.
// No dependencies; rlm_front, rlm_queue, rlm_back and the core top level import this package.
package rlm_pkg;

  // Widest row word carried through the command queue
  localparam int MaxColumns = 64;

  // Command queue depth between front and back
  localparam int QueueDepth = 2;

  // Incoming function codes
  localparam logic [2:0] FN_SET_PIXEL = 3'd0;
  localparam logic [2:0] FN_CLR_PIXEL = 3'd1;
  localparam logic [2:0] FN_ROW_COLOR = 3'd2;
  localparam logic [2:0] FN_ROW_PLANE = 3'd3;
  localparam logic [2:0] FN_CLEAR_ALL = 3'd4;
  localparam logic [2:0] FN_FILL      = 3'd5;
  localparam logic [2:0] FN_TICK      = 3'd6;

  // Internal operation codes after classification
  localparam logic [2:0] OP_SET_PIX   = 3'd0;
  localparam logic [2:0] OP_CLR_PIX   = 3'd1;
  localparam logic [2:0] OP_ROW       = 3'd2;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd3;
  localparam logic [2:0] OP_FILL      = 3'd4;
  localparam logic [2:0] OP_TICK      = 3'd5;

  // Plane numbers (also slice order inside a stored row)
  localparam logic [1:0] PL_RED   = 2'd0;
  localparam logic [1:0] PL_GREEN = 2'd1;
  localparam logic [1:0] PL_BLUE  = 2'd2;

  // Scan phases
  localparam logic [1:0] PH_SHIFT = 2'd0;
  localparam logic [1:0] PH_LATCH = 2'd1;
  localparam logic [1:0] PH_DWELL = 2'd2;
  localparam logic [1:0] PH_OFF   = 2'd3;

  // Classified command; pmask bit p enables plane p (red, green, blue)
  typedef struct packed {
    logic [2:0]            op;
    logic [5:0]            row;
    logic [5:0]            column;
    logic [2:0]            pmask;
    logic [MaxColumns-1:0] data;
  } cmd_t;

  // One pin-state beat
  typedef struct packed {
    logic       top_red;
    logic       top_green;
    logic       top_blue;
    logic       bottom_red;
    logic       bottom_green;
    logic       bottom_blue;
    logic [4:0] row_select;
    logic       shift_clock;
    logic       latch;
    logic       output_enable_n;
    logic       frame_done;
  } beat_t;

endpackage

@@ rtl/core/rlm_if.sv @@
// Channel interfaces: command input, pin-beat output, config write.
// Standalone; no package dependency.
interface rlm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [5:0]  row;
  logic [5:0]  column;
  logic [2:0]  color;
  logic [1:0]  plane;
  logic [63:0] row_data;

  modport source (output valid, func, row, column, color, plane, row_data, input ready);
  modport sink   (input valid, func, row, column, color, plane, row_data, output ready);
endinterface

interface rlm_out_if;
  logic       valid;
  logic       ready;
  logic       top_red;
  logic       top_green;
  logic       top_blue;
  logic       bottom_red;
  logic       bottom_green;
  logic       bottom_blue;
  logic [4:0] row_select;
  logic       shift_clock;
  logic       latch;
  logic       output_enable_n;
  logic       frame_done;

  modport source (output valid, top_red, top_green, top_blue, bottom_red, bottom_green,
                  bottom_blue, row_select, shift_clock, latch, output_enable_n,
                  frame_done, input ready);
  modport sink   (input valid, top_red, top_green, top_blue, bottom_red, bottom_green,
                  bottom_blue, row_select, shift_clock, latch, output_enable_n,
                  frame_done, output ready);
endinterface

interface rlm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] dwell_ticks;

  modport source (output valid, dwell_ticks, input ready);
  modport sink   (input valid, dwell_ticks, output ready);
endinterface

@@ rtl/core/rlm_front.sv @@
// Front end: accepts command transactions and classifies them into queue commands.
// Depends on rlm_pkg and rlm_in_if.
module rlm_front
  import rlm_pkg::*;
#(
  parameter int FRAME_ROWS = 64,
  parameter int COLUMNS    = 64
) (
  rlm_in_if.sink items,
  input  logic   q_full,
  output logic   push,
  output cmd_t   push_cmd
);

  logic       keep;
  logic       row_ok;
  logic       col_ok;
  logic [2:0] color_pm;
  logic [2:0] plane_pm;

  assign items.ready = !q_full;

  // Range checks and plane masks
  assign row_ok   = 7'(items.row) < 7'(FRAME_ROWS);
  assign col_ok   = 7'(items.column) < 7'(COLUMNS);
  // color bit0 blue, bit1 green, bit2 red -> plane order red, green, blue
  assign color_pm = {items.color[0], items.color[1], items.color[2]};

  always_comb begin
    unique case (items.plane)
      PL_RED:   plane_pm = 3'b001;
      PL_GREEN: plane_pm = 3'b010;
      PL_BLUE:  plane_pm = 3'b100;
      default:  plane_pm = 3'b000;
    endcase
  end

  // Classify; writes that change nothing are dropped here
  always_comb begin
    push_cmd.row    = items.row;
    push_cmd.column = items.column;
    push_cmd.data   = items.row_data;
    push_cmd.pmask  = color_pm;
    push_cmd.op     = OP_TICK;
    keep            = 1'b0;
    unique case (items.func)
      FN_SET_PIXEL: begin
        push_cmd.op = OP_SET_PIX;
        keep        = row_ok && col_ok && (color_pm != 3'b000);
      end
      FN_CLR_PIXEL: begin
        push_cmd.op    = OP_CLR_PIX;
        push_cmd.pmask = 3'b111;
        keep           = row_ok && col_ok;
      end
      FN_ROW_COLOR: begin
        push_cmd.op = OP_ROW;
        keep        = row_ok && (color_pm != 3'b000);
      end
      FN_ROW_PLANE: begin
        push_cmd.op    = OP_ROW;
        push_cmd.pmask = plane_pm;
        keep           = row_ok && (plane_pm != 3'b000);
      end
      FN_CLEAR_ALL: begin
        push_cmd.op = OP_CLEAR_ALL;
        keep        = 1'b1;
      end
      FN_FILL: begin
        push_cmd.op = OP_FILL;
        keep        = color_pm != 3'b000;
      end
      FN_TICK: begin
        push_cmd.op = OP_TICK;
        keep        = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = items.valid && items.ready && keep;

endmodule

@@ rtl/core/rlm_queue.sv @@
// Short command FIFO that decouples the front end from the back end.
// Depends on rlm_pkg.
module rlm_queue
  import rlm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int QPtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW = $clog2(QueueDepth + 1);

  cmd_t             slots [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign full  = count == QCntW'(QueueDepth);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ rtl/core/rlm_back.sv @@
// Back end: frame store, store updates, scan sequencer and beat output register.
// Depends on rlm_pkg and rlm_out_if.
module rlm_back
  import rlm_pkg::*;
#(
  parameter int FRAME_ROWS = 64,
  parameter int SCAN_ROWS  = 32,
  parameter int COLUMNS    = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  input  logic [15:0] dwell_ticks,
  rlm_out_if.source   beats
);

  localparam int RowW  = $clog2(FRAME_ROWS);
  localparam int ScanW = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
  localparam int ColW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int WordW = 3 * COLUMNS;
  localparam logic [COLUMNS-1:0] OneBit = COLUMNS'(1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FREAD = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]       state, state_next;
  cmd_t             cmd;
  logic [RowW-1:0]  wr_row;

  // Frame store: one word per frame row holding red, green, blue slices
  logic [WordW-1:0]      mem [FRAME_ROWS];
  logic [FRAME_ROWS-1:0] vld;
  logic [WordW-1:0]      rd_a, rd_b;
  logic                  rd_va, rd_vb, top_ok, bot_ok;

  // Scan state
  logic [ScanW-1:0] scan_row, scan_row_next;
  logic [ColW-1:0]  scan_column, scan_column_next;
  logic [15:0]      dwell_count, dwell_count_next;
  logic [1:0]       scan_phase, scan_phase_next;

  logic             out_valid;
  beat_t            out_beat;

  logic             re, we, out_free, tick_fire, fill_last;
  logic [RowW-1:0]  ra, rb;
  logic [6:0]       bot_row;
  logic [WordW-1:0] old_word, new_word, topw, botw;
  logic [COLUMNS-1:0] bm;
  logic [COLUMNS-1:0] tp [3];
  logic [COLUMNS-1:0] bp [3];
  logic [ColW-1:0]  bit_idx;
  logic [15:0]      dwell_inc;
  beat_t            beat;

  // Control decode
  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign re        = q_pop || (state == S_FREAD);
  assign we        = (state == S_EXEC) && (cmd.op != OP_TICK);
  assign out_free  = !out_valid || beats.ready;
  assign tick_fire = (state == S_EXEC) && (cmd.op == OP_TICK) && out_free;
  assign fill_last = wr_row == RowW'(FRAME_ROWS - 1);
  assign bot_row   = 7'(scan_row) + 7'(SCAN_ROWS);
  assign rb        = bot_row[RowW-1:0];

  always_comb begin
    if (state == S_FREAD) begin
      ra = wr_row;
    end else if (q_head.op == OP_TICK) begin
      ra = RowW'(scan_row);
    end else if (q_head.op == OP_FILL) begin
      ra = '0;
    end else begin
      ra = q_head.row[RowW-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_pop && (q_head.op != OP_CLEAR_ALL)) begin
          state_next = S_EXEC;
        end
      end
      S_FREAD: state_next = S_EXEC;
      S_EXEC: begin
        if (cmd.op == OP_TICK) begin
          if (out_free) begin
            state_next = S_IDLE;
          end
        end else if ((cmd.op == OP_FILL) && !fill_last) begin
          state_next = S_FREAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command and target row
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd    <= q_head;
      wr_row <= (q_head.op == OP_FILL) ? '0 : q_head.row[RowW-1:0];
    end else if ((state == S_EXEC) && (cmd.op == OP_FILL) && !fill_last) begin
      wr_row <= wr_row + 1'b1;
    end
  end

  // Row valid bits: reset and clear-all empty the store at once
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (q_pop && (q_head.op == OP_CLEAR_ALL)) begin
      vld <= '0;
    end else if (we) begin
      vld[wr_row] <= 1'b1;
    end
  end

  // Store memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_row] <= new_word;
    end
    if (re) begin
      rd_a   <= mem[ra];
      rd_b   <= mem[rb];
      rd_va  <= vld[ra];
      rd_vb  <= vld[rb];
      top_ok <= 7'(scan_row) < 7'(FRAME_ROWS);
      bot_ok <= bot_row < 7'(FRAME_ROWS);
    end
  end

  // Read-modify-write of one row
  assign old_word = rd_va ? rd_a : '0;
  assign bm       = OneBit << cmd.column;

  always_comb begin
    logic [COLUMNS-1:0] ow;
    logic [COLUMNS-1:0] nw;
    new_word = old_word;
    for (int p = 0; p < 3; p++) begin
      ow = old_word[p*COLUMNS +: COLUMNS];
      case (cmd.op)
        OP_SET_PIX: nw = ow | bm;
        OP_CLR_PIX: nw = ow & ~bm;
        default:    nw = cmd.data[COLUMNS-1:0];
      endcase
      new_word[p*COLUMNS +: COLUMNS] = cmd.pmask[p] ? nw : ow;
    end
  end

  // Beat generation
  assign topw    = (rd_va && top_ok) ? rd_a : '0;
  assign botw    = (rd_vb && bot_ok) ? rd_b : '0;
  assign bit_idx = ColW'(COLUMNS - 1) - scan_column;

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      tp[p] = topw[p*COLUMNS +: COLUMNS];
      bp[p] = botw[p*COLUMNS +: COLUMNS];
    end
  end

  always_comb begin
    beat            = '0;
    beat.row_select = 5'(scan_row);
    case (scan_phase)
      PH_SHIFT: begin
        beat.top_red         = tp[PL_RED][bit_idx];
        beat.top_green       = tp[PL_GREEN][bit_idx];
        beat.top_blue        = tp[PL_BLUE][bit_idx];
        beat.bottom_red      = bp[PL_RED][bit_idx];
        beat.bottom_green    = bp[PL_GREEN][bit_idx];
        beat.bottom_blue     = bp[PL_BLUE][bit_idx];
        beat.shift_clock     = 1'b1;
        beat.output_enable_n = 1'b1;
      end
      PH_LATCH: beat.latch = 1'b1;
      PH_DWELL: beat.latch = 1'b0;
      default: begin
        beat.output_enable_n = 1'b1;
        beat.frame_done      = 1'b1;
      end
    endcase
  end

  // Scan state update on each delivered tick
  assign dwell_inc = dwell_count + 16'd1;

  always_comb begin
    logic advance;
    advance          = 1'b0;
    scan_row_next    = scan_row;
    scan_column_next = scan_column;
    dwell_count_next = dwell_count;
    scan_phase_next  = scan_phase;
    if (tick_fire) begin
      case (scan_phase)
        PH_SHIFT: begin
          if (scan_column == ColW'(COLUMNS - 1)) begin
            scan_column_next = '0;
            scan_phase_next  = PH_LATCH;
          end else begin
            scan_column_next = scan_column + 1'b1;
          end
        end
        PH_LATCH: begin
          if (dwell_ticks == 16'd0) begin
            advance = 1'b1;
          end else begin
            dwell_count_next = '0;
            scan_phase_next  = PH_DWELL;
          end
        end
        PH_DWELL: begin
          dwell_count_next = dwell_inc;
          advance          = (dwell_inc >= dwell_ticks) || (dwell_inc == 16'd0);
        end
        default: begin
          scan_row_next    = '0;
          scan_column_next = '0;
          dwell_count_next = '0;
          scan_phase_next  = PH_SHIFT;
        end
      endcase
      // Move to the next scan row, or blank after the last one
      if (advance) begin
        if (scan_row == ScanW'(SCAN_ROWS - 1)) begin
          scan_phase_next = PH_OFF;
        end else begin
          scan_row_next    = scan_row + 1'b1;
          scan_column_next = '0;
          scan_phase_next  = PH_SHIFT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row    <= '0;
      scan_column <= '0;
      dwell_count <= '0;
      scan_phase  <= PH_SHIFT;
    end else begin
      scan_row    <= scan_row_next;
      scan_column <= scan_column_next;
      dwell_count <= dwell_count_next;
      scan_phase  <= scan_phase_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= 1'b1;
    end else if (beats.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      out_beat <= beat;
    end
  end

  assign beats.valid           = out_valid;
  assign beats.top_red         = out_beat.top_red;
  assign beats.top_green       = out_beat.top_green;
  assign beats.top_blue        = out_beat.top_blue;
  assign beats.bottom_red      = out_beat.bottom_red;
  assign beats.bottom_green    = out_beat.bottom_green;
  assign beats.bottom_blue     = out_beat.bottom_blue;
  assign beats.row_select      = out_beat.row_select;
  assign beats.shift_clock     = out_beat.shift_clock;
  assign beats.latch           = out_beat.latch;
  assign beats.output_enable_n = out_beat.output_enable_n;
  assign beats.frame_done      = out_beat.frame_done;

endmodule

@@ rtl/core/rgb_led_matrix_scan_controller_core.sv @@
// Commands are queued, then popped with a registered store read and executed: a write
// updates the store; a tick loads its beat into the output register, waiting while
// the output stalls. One command at a time: a store read, then a write or beat; fill
// repeats both per frame row. The single write port and registered reads set this pace.
// Reset: synchronous; per-row valid bits empty the store at once, no clearing pass.
// Depends on rlm_pkg, rlm_if, rlm_front, rlm_queue and rlm_back.
module rgb_led_matrix_scan_controller_core
  import rlm_pkg::*;
#(
  parameter int FRAME_ROWS = 64,
  parameter int SCAN_ROWS  = 32,
  parameter int COLUMNS    = 64
) (
  input logic      clk,
  input logic      rst,
  rlm_in_if.sink   items,
  rlm_out_if.source beats,
  rlm_cfg_if.sink  cfg
);

  logic        q_full, q_empty, q_push, q_pop;
  cmd_t        push_cmd, q_head;
  logic [15:0] dwell_ticks;

  // Dwell register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_ticks <= 16'd250;
    end else if (cfg.valid) begin
      dwell_ticks <= cfg.dwell_ticks;
    end
  end

  rlm_front #(
    .FRAME_ROWS (FRAME_ROWS),
    .COLUMNS    (COLUMNS)
  ) u_front (
    .items    (items),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (push_cmd)
  );

  rlm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  rlm_back #(
    .FRAME_ROWS (FRAME_ROWS),
    .SCAN_ROWS  (SCAN_ROWS),
    .COLUMNS    (COLUMNS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .dwell_ticks (dwell_ticks),
    .beats       (beats)
  );

endmodule

@@ rtl/core/rlm_checker.sv @@
// Port-level checks on the scan controller's beat output, bound to the top level.
// Depends only on the top level's ports.
module rlm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       top_red,
  input logic       top_green,
  input logic       top_blue,
  input logic       bottom_red,
  input logic       bottom_green,
  input logic       bottom_blue,
  input logic [4:0] row_select,
  input logic       shift_clock,
  input logic       latch,
  input logic       output_enable_n,
  input logic       frame_done
);

  // Stalled beat holds valid and its control pins
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_select) && $stable(shift_clock)
      && $stable(latch) && $stable(output_enable_n) && $stable(frame_done))
    else $error("stalled beat changed");

  // Beat kinds are exclusive and set the display enable
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!shift_clock || (!latch && output_enable_n && !frame_done))
      && (!latch || (!output_enable_n && !frame_done)))
    else $error("inconsistent beat kind");

  // Color lines are quiet outside shift beats
  a_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && !shift_clock |-> !top_red && !top_green && !top_blue
      && !bottom_red && !bottom_green && !bottom_blue)
    else $error("color on non-shift beat");

  // No beat right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("beat valid after reset");

endmodule

bind rgb_led_matrix_scan_controller_core rlm_checker u_rlm_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (beats.valid),
  .out_ready       (beats.ready),
  .top_red         (beats.top_red),
  .top_green       (beats.top_green),
  .top_blue        (beats.top_blue),
  .bottom_red      (beats.bottom_red),
  .bottom_green    (beats.bottom_green),
  .bottom_blue     (beats.bottom_blue),
  .row_select      (beats.row_select),
  .shift_clock     (beats.shift_clock),
  .latch           (beats.latch),
  .output_enable_n (beats.output_enable_n),
  .frame_done      (beats.frame_done)
);

@@ dv/rgb_led_matrix_scan_controller_core_tb.sv @@
// Self-checking testbench for the LED matrix scan controller core.
// Holds a shadow frame store and scan sequencer that predict every pin beat.
// Depends on rlm_pkg, the rlm_if channel interfaces and the core RTL.
module rgb_led_matrix_scan_controller_core_tb;
  import rlm_pkg::*;

  // Panel geometry, matching the core's defaults
  localparam int FrameRows = 64;
  localparam int ScanRows  = 32;
  localparam int Columns   = 64;
  localparam logic [63:0] ColMask = (Columns >= 64) ? '1 : ((64'd1 << Columns) - 64'd1);

  // Function code the core ignores
  localparam logic [2:0] FnUnused = 3'd7;

  // Colour mask bits
  localparam logic [2:0] MaskBlue  = 3'b001;
  localparam logic [2:0] MaskGreen = 3'b010;
  localparam logic [2:0] MaskRed   = 3'b100;
  localparam logic [2:0] MaskAll   = 3'b111;

  localparam logic [1:0] PlaneNone = 2'd3;
  localparam logic [15:0] DwellReset = 16'd250;

  // Wait after the last beat before a register write: covers two queued fills
  localparam int SettleCycles = 400;
  localparam int TailCycles   = 10;
  localparam int WatchdogLimit = 4000;
  localparam int MaxPrinted   = 40;

  typedef struct {
    logic [2:0]  func;
    logic [5:0]  row;
    logic [5:0]  column;
    logic [2:0]  color;
    logic [1:0]  plane;
    logic [63:0] data;
  } cmd_item_t;

  typedef struct {
    cmd_item_t item;
    bit        typed;
    beat_t     beat;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  rlm_in_if  in_ch ();
  rlm_out_if out_ch ();
  rlm_cfg_if cfg_ch ();

  rgb_led_matrix_scan_controller_core dut (
    .clk   (clk),
    .rst   (rst),
    .items (in_ch),
    .beats (out_ch),
    .cfg   (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the core's state
  logic [63:0] shadow_planes [0:3*FrameRows-1];
  logic [4:0]  scan_row;
  logic [6:0]  scan_col;
  logic [15:0] dwell_cnt;
  logic [1:0]  scan_phase;
  logic [15:0] dwell_cfg;

  beat_t     beats_due [$];
  plan_row_t dir_plan [$];
  beat_t     seen_beat;
  beat_t     due_beat;

  int errors;
  int beat_no;
  int idle_pct;
  int stall_left;
  int quiet_cycles;

  // ---------------------------------------------------------------- predictor

  function automatic int plane_index(logic [5:0] r, logic [1:0] p);
    return int'(r) * 3 + int'(p);
  endfunction

  function automatic void put_colour_row(logic [5:0] r, logic [2:0] mask, logic [63:0] w);
    if ((mask & MaskBlue) != 0) shadow_planes[plane_index(r, PL_BLUE)] = w & ColMask;
    if ((mask & MaskGreen) != 0) shadow_planes[plane_index(r, PL_GREEN)] = w & ColMask;
    if ((mask & MaskRed) != 0) shadow_planes[plane_index(r, PL_RED)] = w & ColMask;
  endfunction

  // Apply one store write; rows and columns always fall inside the default geometry
  function automatic void apply_write(cmd_item_t it);
    case (it.func)
      FN_SET_PIXEL: begin
        if ((it.color & MaskBlue) != 0) shadow_planes[plane_index(it.row, PL_BLUE)][it.column] = 1'b1;
        if ((it.color & MaskGreen) != 0)
          shadow_planes[plane_index(it.row, PL_GREEN)][it.column] = 1'b1;
        if ((it.color & MaskRed) != 0) shadow_planes[plane_index(it.row, PL_RED)][it.column] = 1'b1;
      end
      FN_CLR_PIXEL: begin
        shadow_planes[plane_index(it.row, PL_RED)][it.column] = 1'b0;
        shadow_planes[plane_index(it.row, PL_GREEN)][it.column] = 1'b0;
        shadow_planes[plane_index(it.row, PL_BLUE)][it.column] = 1'b0;
      end
      FN_ROW_COLOR: put_colour_row(it.row, it.color, it.data);
      FN_ROW_PLANE: begin
        // plane three is dropped
        if (it.plane != PlaneNone) shadow_planes[plane_index(it.row, it.plane)] = it.data & ColMask;
      end
      FN_CLEAR_ALL: begin
        foreach (shadow_planes[i]) shadow_planes[i] = '0;
      end
      FN_FILL: begin
        for (int r = 0; r < FrameRows; r++) put_colour_row(6'(r), it.color, it.data);
      end
      default: ;
    endcase
  endfunction

  function automatic void next_scan_row();
    if (int'(scan_row) + 1 >= ScanRows) begin
      scan_phase = PH_OFF;
    end else begin
      scan_row   = scan_row + 5'd1;
      scan_col   = '0;
      scan_phase = PH_SHIFT;
    end
  endfunction

  // One tick of the scan: returns the pin beat and advances the sequencer
  function automatic beat_t panel_beat();
    beat_t      b;
    logic [5:0] bitn;
    int         top_i;
    int         bot_i;
    b = '0;
    b.row_select = scan_row;
    case (scan_phase)
      PH_SHIFT: begin
        bitn  = 6'(Columns - 1 - int'(scan_col));
        top_i = int'(scan_row) * 3;
        bot_i = (int'(scan_row) + ScanRows) * 3;
        b.top_red   = shadow_planes[top_i + int'(PL_RED)][bitn];
        b.top_green = shadow_planes[top_i + int'(PL_GREEN)][bitn];
        b.top_blue  = shadow_planes[top_i + int'(PL_BLUE)][bitn];
        // bottom half row may lie outside a short frame
        if (int'(scan_row) + ScanRows < FrameRows) begin
          b.bottom_red   = shadow_planes[bot_i + int'(PL_RED)][bitn];
          b.bottom_green = shadow_planes[bot_i + int'(PL_GREEN)][bitn];
          b.bottom_blue  = shadow_planes[bot_i + int'(PL_BLUE)][bitn];
        end
        b.shift_clock     = 1'b1;
        b.output_enable_n = 1'b1;
        scan_col = scan_col + 7'd1;
        if (int'(scan_col) >= Columns) begin
          scan_col   = '0;
          scan_phase = PH_LATCH;
        end
      end
      PH_LATCH: begin
        b.latch = 1'b1;
        if (dwell_cfg == 0) begin
          next_scan_row();
        end else begin
          dwell_cnt  = '0;
          scan_phase = PH_DWELL;
        end
      end
      PH_DWELL: begin
        // a lowered dwell setting ends the dwell at the next beat
        dwell_cnt = dwell_cnt + 16'd1;
        if (dwell_cnt >= dwell_cfg || dwell_cnt == 0) next_scan_row();
      end
      default: begin
        b.output_enable_n = 1'b1;
        b.frame_done      = 1'b1;
        scan_row   = '0;
        scan_col   = '0;
        dwell_cnt  = '0;
        scan_phase = PH_SHIFT;
      end
    endcase
    return b;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_error(string msg);
    errors++;
    if (errors <= MaxPrinted) $display("ERROR: %s", msg);
  endtask

  task automatic compare_pin(string pin, logic [4:0] got, logic [4:0] want);
    if (got !== want)
      flag_error($sformatf("beat %0d %s: got %0d expected %0d", beat_no, pin, got, want));
  endtask

  // Output monitor: each beat transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen_beat.top_red         = out_ch.top_red;
      seen_beat.top_green       = out_ch.top_green;
      seen_beat.top_blue        = out_ch.top_blue;
      seen_beat.bottom_red      = out_ch.bottom_red;
      seen_beat.bottom_green    = out_ch.bottom_green;
      seen_beat.bottom_blue     = out_ch.bottom_blue;
      seen_beat.row_select      = out_ch.row_select;
      seen_beat.shift_clock     = out_ch.shift_clock;
      seen_beat.latch           = out_ch.latch;
      seen_beat.output_enable_n = out_ch.output_enable_n;
      seen_beat.frame_done      = out_ch.frame_done;
      if (beats_due.size() == 0) begin
        flag_error($sformatf("beat %0d arrived with nothing expected", beat_no));
      end else begin
        due_beat = beats_due.pop_front();
        compare_pin("top_red", 5'(seen_beat.top_red), 5'(due_beat.top_red));
        compare_pin("top_green", 5'(seen_beat.top_green), 5'(due_beat.top_green));
        compare_pin("top_blue", 5'(seen_beat.top_blue), 5'(due_beat.top_blue));
        compare_pin("bottom_red", 5'(seen_beat.bottom_red), 5'(due_beat.bottom_red));
        compare_pin("bottom_green", 5'(seen_beat.bottom_green), 5'(due_beat.bottom_green));
        compare_pin("bottom_blue", 5'(seen_beat.bottom_blue), 5'(due_beat.bottom_blue));
        compare_pin("row_select", seen_beat.row_select, due_beat.row_select);
        compare_pin("shift_clock", 5'(seen_beat.shift_clock), 5'(due_beat.shift_clock));
        compare_pin("latch", 5'(seen_beat.latch), 5'(due_beat.latch));
        compare_pin("output_enable_n", 5'(seen_beat.output_enable_n),
                    5'(due_beat.output_enable_n));
        compare_pin("frame_done", 5'(seen_beat.frame_done), 5'(due_beat.frame_done));
      end
      beat_no++;
    end
  end

  // Watchdog: cycles without any transaction on any channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("watchdog: no transaction for %0d cycles", quiet_cycles);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // Beat receiver: ready drops in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      stall_left = $urandom_range(5, 0);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic cmd_item_t mk_item(logic [2:0] func, logic [5:0] row, logic [5:0] column,
                                        logic [2:0] color, logic [1:0] plane, logic [63:0] data);
    cmd_item_t it;
    it.func   = func;
    it.row    = row;
    it.column = column;
    it.color  = color;
    it.plane  = plane;
    it.data   = data;
    return it;
  endfunction

  // Expected beat typed in by hand: top and bottom as {red, green, blue}
  function automatic beat_t mk_beat(logic [2:0] top, logic [2:0] bot, logic [4:0] rs,
                                    logic sc, logic lt, logic oe, logic fd);
    beat_t b;
    {b.top_red, b.top_green, b.top_blue}          = top;
    {b.bottom_red, b.bottom_green, b.bottom_blue} = bot;
    b.row_select      = rs;
    b.shift_clock     = sc;
    b.latch           = lt;
    b.output_enable_n = oe;
    b.frame_done      = fd;
    return b;
  endfunction

  task automatic add_row(cmd_item_t it, bit typed = 1'b0, beat_t b = '0);
    plan_row_t pr;
    pr.item  = it;
    pr.typed = typed;
    pr.beat  = b;
    dir_plan.push_back(pr);
  endtask

  function automatic cmd_item_t random_item(int tick_pct);
    cmd_item_t it;
    int        pick;
    it.row    = 6'($urandom_range(63));
    it.column = 6'($urandom_range(63));
    it.color  = 3'($urandom_range(7));
    it.plane  = 2'($urandom_range(3));
    case ($urandom_range(7))
      0:       it.data = '1;
      1:       it.data = '0;
      default: it.data = {$urandom, $urandom};
    endcase
    if ($urandom_range(99) < tick_pct) begin
      it.func = FN_TICK;
    end else begin
      pick = $urandom_range(99);
      if (pick < 25)      it.func = FN_SET_PIXEL;
      else if (pick < 40) it.func = FN_CLR_PIXEL;
      else if (pick < 65) it.func = FN_ROW_COLOR;
      else if (pick < 88) it.func = FN_ROW_PLANE;
      else if (pick < 92) it.func = FN_FILL;
      else if (pick < 94) it.func = FN_CLEAR_ALL;
      else                it.func = FnUnused;
    end
    return it;
  endfunction

  // Drive one command transaction; entered and left at a falling edge
  task automatic send_item(cmd_item_t it, bit typed = 1'b0, beat_t lit = '0);
    beat_t b;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= it.func;
    in_ch.row      <= it.row;
    in_ch.column   <= it.column;
    in_ch.color    <= it.color;
    in_ch.plane    <= it.plane;
    in_ch.row_data <= it.data;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (it.func == FN_TICK) begin
      b = panel_beat();
      beats_due.push_back(typed ? lit : b);
    end else begin
      apply_write(it);
    end
    @(negedge clk);
  endtask

  task automatic run_random(int count, int tick_pct, bit vary_idle);
    for (int n = 0; n < count; n++) begin
      if (vary_idle && n % 50 == 0) idle_pct = ($urandom_range(1) != 0) ? 30 : 0;
      send_item(random_item(tick_pct));
    end
  endtask

  // Let every expected beat come back and any slow write finish
  task automatic settle(int extra);
    in_ch.valid <= 1'b0;
    while (beats_due.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_dwell(logic [15:0] value);
    settle(SettleCycles);
    cfg_ch.dwell_ticks <= value;
    cfg_ch.valid       <= 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    dwell_cfg = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- main flow

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.func = FN_TICK;
    in_ch.row = '0;
    in_ch.column = '0;
    in_ch.color = '0;
    in_ch.plane = '0;
    in_ch.row_data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.dwell_ticks = '0;

    foreach (shadow_planes[i]) shadow_planes[i] = '0;
    scan_row = '0;
    scan_col = '0;
    dwell_cnt = '0;
    scan_phase = PH_SHIFT;
    dwell_cfg = DwellReset;
    errors = 0;
    beat_no = 0;
    stall_left = 0;
    quiet_cycles = 0;
    idle_pct = 30;

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed table; columns scan from bit 63 downward, one per tick
    add_row(mk_item(FN_TICK, 6'd0, 6'd0, 3'd0, 2'd0, '0), 1'b1,
            mk_beat(3'b000, 3'b000, 5'd0, 1'b1, 1'b0, 1'b1, 1'b0));
    add_row(mk_item(FN_SET_PIXEL, 6'd0, 6'd62, MaskAll, 2'd0, '0));
    add_row(mk_item(FN_TICK, 6'd63, 6'd63, 3'd7, 2'd3, '1), 1'b1,
            mk_beat(3'b111, 3'b000, 5'd0, 1'b1, 1'b0, 1'b1, 1'b0));
    add_row(mk_item(FN_SET_PIXEL, 6'd32, 6'd61, MaskRed | MaskBlue, 2'd0, '0));
    add_row(mk_item(FN_TICK, 6'd0, 6'd0, 3'd0, 2'd0, '0), 1'b1,
            mk_beat(3'b000, 3'b101, 5'd0, 1'b1, 1'b0, 1'b1, 1'b0));
    add_row(mk_item(FN_ROW_COLOR, 6'd0, 6'd0, MaskGreen, 2'd0, '1));
    add_row(mk_item(FN_TICK, 6'd0, 6'd0, 3'd0, 2'd0, '0));
    // plane three write must leave the store alone
    add_row(mk_item(FN_ROW_PLANE, 6'd32, 6'd0, 3'd0, PlaneNone, '1));
    add_row(mk_item(FN_TICK, 6'd0, 6'd0, 3'd0, 2'd0, '0));
    add_row(mk_item(FN_ROW_PLANE, 6'd32, 6'd0, 3'd0, PL_BLUE, 64'h5555_5555_5555_5555));
    add_row(mk_item(FN_TICK, 6'd0, 6'd0, 3'd0, 2'd0, '0));
    add_row(mk_item(FN_CLR_PIXEL, 6'd0, 6'd57, 3'd0, 2'd0, '0));
    add_row(mk_item(FN_TICK, 6'd0, 6'd0, 3'd0, 2'd0, '0));
    // unused function code, would set bit 63 of row 63 if decoded as a write
    add_row(mk_item(FnUnused, 6'd63, 6'd63, MaskAll, 2'd3, '1));
    add_row(mk_item(FN_TICK, 6'd0, 6'd0, 3'd0, 2'd0, '0));
    add_row(mk_item(FN_FILL, 6'd0, 6'd0, MaskAll, 2'd0, '0));
    add_row(mk_item(FN_TICK, 6'd0, 6'd0, 3'd0, 2'd0, '0), 1'b1,
            mk_beat(3'b000, 3'b000, 5'd0, 1'b1, 1'b0, 1'b1, 1'b0));
    add_row(mk_item(FN_FILL, 6'd0, 6'd0, MaskRed, 2'd0, '1));
    add_row(mk_item(FN_TICK, 6'd0, 6'd0, 3'd0, 2'd0, '0));
    add_row(mk_item(FN_CLEAR_ALL, 6'd0, 6'd0, 3'd0, 2'd0, '0));
    add_row(mk_item(FN_TICK, 6'd0, 6'd0, 3'd0, 2'd0, '0), 1'b1,
            mk_beat(3'b000, 3'b000, 5'd0, 1'b1, 1'b0, 1'b1, 1'b0));
    add_row(mk_item(FN_SET_PIXEL, 6'd63, 6'd0, MaskAll, 2'd0, '0));
    add_row(mk_item(FN_ROW_PLANE, 6'd31, 6'd0, 3'd0, PL_GREEN, 64'd1));
    add_row(mk_item(FN_ROW_COLOR, 6'd63, 6'd0, 3'd0, 2'd0, '1));
    add_row(mk_item(FN_ROW_PLANE, 6'd0, 6'd0, 3'd0, PL_RED, 64'h8000_0000_0000_0001));

    foreach (dir_plan[i]) send_item(dir_plan[i].item, dir_plan[i].typed, dir_plan[i].beat);

    // Longest dwell; tick-heavy so the scan reaches the latch and dwells a while
    set_dwell(16'hFFFF);
    idle_pct = 40;
    run_random(130, 60, 1'b0);

    // Lowered mid-dwell: the dwell ends on the next beat
    set_dwell(16'd2);
    run_random(150, 50, 1'b1);

    // No dwell: the next row follows the latch beat directly
    set_dwell(16'd0);
    run_random(100, 85, 1'b1);

    // Closing stretch with both sides always ready
    set_dwell(16'd1);
    idle_pct = 0;
    run_random(145, 70, 1'b0);

    settle(TailCycles);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
